// File: hw/rtl/banked_size_class_slot_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// banked_size_class_slot_allocator_unit_defines.svh
// Assertion macros used by the slot allocator top-level RTL.
// ----------------------------------------------------------------------------
`ifndef BANKED_SIZE_CLASS_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define BANKED_SIZE_CLASS_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define BSCSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset
`define BSCSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bscsa_pkg.sv
// ----------------------------------------------------------------------------
// bscsa_pkg
// Types, constants and helpers of the banked size-class slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bscsa_pkg;

    // Sizing
    localparam int MAX_BANKS   = 8;
    localparam int MAX_SLOTS   = 16;
    localparam int NUM_CLASSES = 3;
    localparam int NUM_LISTS   = MAX_BANKS * NUM_CLASSES;
    localparam int RAM_DEPTH   = NUM_LISTS * MAX_SLOTS;

    // Field widths
    localparam int ACTION_W     = 1;
    localparam int CLASS_W      = 2;
    localparam int BANK_W       = 3;
    localparam int SLOT_W       = 5;
    localparam int STATUS_W     = 2;
    localparam int BANKS_REG_W  = 4;
    localparam int CAP_W        = 5;

    // Derived widths
    localparam int NB_W   = $clog2(MAX_BANKS + 1);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int POS_W  = $clog2(MAX_SLOTS);
    localparam int LIST_W = $clog2(NUM_LISTS);
    localparam int ADDR_W = $clog2(RAM_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE  = CFG_IDX_W'(3);

    // Reset values of the registers
    localparam logic [BANKS_REG_W-1:0] RST_BANKS = BANKS_REG_W'(1);
    localparam logic [CAP_W-1:0]       RST_CAP   = CAP_W'(10);

    // Request codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_SMALL  = CLASS_W'(0);
    localparam logic [CLASS_W-1:0] CLS_MEDIUM = CLASS_W'(1);
    localparam logic [CLASS_W-1:0] CLS_LARGE  = CLASS_W'(2);

    typedef enum logic [STATUS_W-1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_RELEASED  = 2'd2,
        STAT_REJECTED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // Request and result transactions
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CLASS_W-1:0]  size_class;
        logic [BANK_W-1:0]   bank;
        logic [SLOT_W-1:0]   slot;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [BANK_W-1:0]   granted_bank;
        logic [SLOT_W-1:0]   granted_slot;
    } t_result;

    // Effective capacity per class
    typedef logic [NUM_CLASSES-1:0][CNT_W-1:0] t_caps;

    typedef struct packed {
        logic [NB_W-1:0] banks;
        t_caps           caps;
    } t_list_cfg;

    // Decision of the list controller for one request
    typedef struct packed {
        t_status             status;
        logic [BANK_W-1:0]   bank;
        logic                use_init;
        logic [SLOT_W-1:0]   init_slot;
        logic                ram_we;
        logic [ADDR_W-1:0]   ram_addr;
        logic [SLOT_W-1:0]   ram_wdata;
    } t_dec;

    // Bank count clipped to the number of banks built
    function automatic logic [NB_W-1:0] eff_banks(input logic [BANKS_REG_W-1:0] raw);
        logic [NB_W-1:0] res;
        if (int'(raw) > MAX_BANKS) begin
            res = NB_W'(MAX_BANKS);
        end else begin
            res = NB_W'(raw);
        end
        return res;
    endfunction

    // Capacity clipped to the slots per list
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] raw);
        logic [CNT_W-1:0] res;
        if (int'(raw) > MAX_SLOTS) begin
            res = CNT_W'(MAX_SLOTS);
        end else begin
            res = CNT_W'(raw);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bscsa_ram.sv
// ----------------------------------------------------------------------------
// bscsa_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bscsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/bscsa_lists.sv
// ----------------------------------------------------------------------------
// bscsa_lists
// Head, count and write-fill registers of every free list; picks the bank
// for an allocate, checks a release and forms the slot store access.
// ----------------------------------------------------------------------------
`default_nettype none

module bscsa_lists (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_exec,
    input  bscsa_pkg::t_req       i_req,
    input  bscsa_pkg::t_list_cfg  i_cfg,
    input  logic                  i_init,
    input  bscsa_pkg::t_caps      i_init_caps,
    output bscsa_pkg::t_dec       o_dec
);
    import bscsa_pkg::*;

    // Per-list state; r_wcnt counts tail writes since the last reinit
    // (saturating), so a position not yet written still holds its initial slot
    logic [POS_W-1:0] r_head  [NUM_LISTS];
    logic [CNT_W-1:0] r_count [NUM_LISTS];
    logic [CNT_W-1:0] r_wcnt  [NUM_LISTS];

    logic [NUM_LISTS-1:0] nonempty;
    logic                 cls_ok;
    logic [CLASS_W-1:0]   cls_idx;
    logic                 found;
    logic [BANK_W-1:0]    pick_bank;
    logic [BANK_W-1:0]    sel_bank;
    logic [LIST_W-1:0]    li;
    logic [POS_W-1:0]     h;
    logic [CNT_W-1:0]     c;
    logic [CNT_W-1:0]     w;
    logic [CNT_W-1:0]     cap;
    logic [SUM_W-1:0]     tail_sum;
    logic [SUM_W-1:0]     off_sum;
    logic [POS_W-1:0]     pos;
    logic                 written;
    logic                 rel_ok;
    logic                 do_pop;
    logic                 do_push;

    // Non-empty flag of every list
    always_comb begin
        for (int l = 0; l < NUM_LISTS; l++) begin
            nonempty[l] = (r_count[l] != '0);
        end
    end

    // Bank pick, release check and store access
    always_comb begin
        cls_ok  = (int'(i_req.size_class) < NUM_CLASSES);
        cls_idx = cls_ok ? i_req.size_class : CLS_SMALL;
        cap     = i_cfg.caps[cls_idx];

        // lowest bank in use whose list is not empty
        found     = 1'b0;
        pick_bank = '0;
        for (int b = MAX_BANKS - 1; b >= 0; b--) begin
            if (cls_ok && (b < int'(i_cfg.banks))
                    && nonempty[b * NUM_CLASSES + int'(cls_idx)]) begin
                found     = 1'b1;
                pick_bank = BANK_W'(b);
            end
        end

        sel_bank = (i_req.action == ACT_RELEASE) ? i_req.bank : pick_bank;
        li       = LIST_W'(int'(sel_bank) * NUM_CLASSES + int'(cls_idx));
        h        = r_head[li];
        c        = r_count[li];
        w        = r_wcnt[li];

        // tail = (head + count) mod slots
        tail_sum = SUM_W'(h) + SUM_W'(c);
        if (tail_sum >= SUM_W'(MAX_SLOTS)) begin
            tail_sum = tail_sum - SUM_W'(MAX_SLOTS);
        end

        // head distance from the first tail write position
        off_sum = SUM_W'(h) + SUM_W'(MAX_SLOTS) - SUM_W'(cap);
        if (off_sum >= SUM_W'(MAX_SLOTS)) begin
            off_sum = off_sum - SUM_W'(MAX_SLOTS);
        end
        written = (SUM_W'(w) > off_sum);

        rel_ok = cls_ok && (int'(i_req.bank) < int'(i_cfg.banks))
                 && (i_req.slot != '0) && (int'(i_req.slot) <= int'(cap))
                 && (c < cap);

        pos = (i_req.action == ACT_RELEASE) ? tail_sum[POS_W-1:0] : h;

        o_dec.status    = STAT_NO_SPACE;
        o_dec.bank      = '0;
        o_dec.use_init  = 1'b1;
        o_dec.init_slot = '0;
        o_dec.ram_we    = 1'b0;
        o_dec.ram_addr  = ADDR_W'(int'(li) * MAX_SLOTS + int'(pos));
        o_dec.ram_wdata = i_req.slot;

        if (i_req.action == ACT_ALLOC) begin
            if (found) begin
                o_dec.status    = STAT_ALLOCATED;
                o_dec.bank      = pick_bank;
                o_dec.use_init  = !written;
                o_dec.init_slot = SLOT_W'(h) + SLOT_W'(1);
            end
        end else begin
            o_dec.status = STAT_REJECTED;
            if (rel_ok) begin
                o_dec.status = STAT_RELEASED;
                o_dec.ram_we = 1'b1;
            end
        end
    end

    assign do_pop  = i_exec && (i_req.action == ACT_ALLOC) && found;
    assign do_push = i_exec && (i_req.action == ACT_RELEASE) && rel_ok;

    // List registers: reset and reinit refill every list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LISTS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= eff_cap(RST_CAP);
                r_wcnt[l]  <= '0;
            end
        end else if (i_init) begin
            for (int b = 0; b < MAX_BANKS; b++) begin
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    r_head[b * NUM_CLASSES + k]  <= '0;
                    r_count[b * NUM_CLASSES + k] <= i_init_caps[k];
                    r_wcnt[b * NUM_CLASSES + k]  <= '0;
                end
            end
        end else begin
            if (do_pop) begin
                r_head[li]  <= (h == POS_W'(MAX_SLOTS - 1)) ? '0 : h + POS_W'(1);
                r_count[li] <= c - CNT_W'(1);
            end
            if (do_push) begin
                r_count[li] <= c + CNT_W'(1);
                if (w != CNT_W'(MAX_SLOTS)) begin
                    r_wcnt[li] <= w + CNT_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/banked_size_class_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// banked_size_class_slot_allocator_unit
// Slot allocator with up to eight banks and three size classes, each bank
// keeping one FIFO free list per class in a shared slot store RAM.
//
//   channel   direction  handshake                 payload
//   request   in         start, busy               i_req (t_req)
//   result    out        o_done (one-cycle strobe) o_result (t_result)
//   config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request first picks the bank from the list counters and accesses the
// slot store RAM (EXEC), then the registered RAM read returns (RESP).
// Result strobes in the cycle after busy; the next request is taken in that
// same cycle. The receiver cannot stall; o_done lasts exactly one cycle.
// Synchronous reset and config writes to index 0-3 refill all lists at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "banked_size_class_slot_allocator_unit_defines.svh"

module banked_size_class_slot_allocator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  bscsa_pkg::t_req                      i_req,
    output logic                                 o_done,
    output bscsa_pkg::t_result                   o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bscsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bscsa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bscsa_pkg::*;

    t_state                 r_state, n_state;
    t_req                   r_req;
    logic [BANKS_REG_W-1:0] r_banks, n_banks;
    logic [CAP_W-1:0]       r_caps [NUM_CLASSES];
    logic [CAP_W-1:0]       n_caps [NUM_CLASSES];
    logic                   cfg_wr;
    logic                   cfg_init;
    t_list_cfg              list_cfg;
    t_caps                  init_caps;
    logic                   accept;
    logic                   exec;
    t_dec                   dec;
    logic [SLOT_W-1:0]      ram_rdata;
    t_status                r_status;
    logic [BANK_W-1:0]      r_bank;
    logic                   r_use_init;
    logic [SLOT_W-1:0]      r_init_slot;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_banks  = r_banks;
        n_caps   = r_caps;
        cfg_init = 1'b0;
        if (cfg_wr) begin
            case (i_cfg_index)
                CFG_BANKS: begin
                    n_banks  = i_cfg_data[BANKS_REG_W-1:0];
                    cfg_init = 1'b1;
                end
                CFG_SMALL: begin
                    n_caps[CLS_SMALL] = i_cfg_data;
                    cfg_init = 1'b1;
                end
                CFG_MEDIUM: begin
                    n_caps[CLS_MEDIUM] = i_cfg_data;
                    cfg_init = 1'b1;
                end
                CFG_LARGE: begin
                    n_caps[CLS_LARGE] = i_cfg_data;
                    cfg_init = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banks <= RST_BANKS;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_caps[k] <= RST_CAP;
            end
        end else begin
            r_banks <= n_banks;
            r_caps  <= n_caps;
        end
    end

    // Effective settings, current and for a refill
    always_comb begin
        list_cfg.banks = eff_banks(r_banks);
        for (int k = 0; k < NUM_CLASSES; k++) begin
            list_cfg.caps[k] = eff_cap(r_caps[k]);
            init_caps[k]     = eff_cap(n_caps[k]);
        end
    end

    // Sequencer
    assign busy   = (r_state == ST_EXEC);
    assign accept = start && !busy;
    assign exec   = (r_state == ST_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_state = accept ? ST_EXEC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    // List controller
    bscsa_lists u_lists (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_exec      (exec),
        .i_req       (r_req),
        .i_cfg       (list_cfg),
        .i_init      (cfg_init),
        .i_init_caps (init_caps),
        .o_dec       (dec)
    );

    // Slot store
    bscsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (exec && dec.ram_we),
        .i_addr  (dec.ram_addr),
        .i_wdata (dec.ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Result held while the RAM read returns
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status    <= dec.status;
            r_bank      <= dec.bank;
            r_use_init  <= dec.use_init;
            r_init_slot <= dec.init_slot;
        end
    end

    assign o_done                = (r_state == ST_RESP);
    assign o_result.status       = r_status;
    assign o_result.granted_bank = r_bank;
    assign o_result.granted_slot = r_use_init ? r_init_slot : ram_rdata;

    // Checks
    `BSCSA_ASSERT_NXT(a_exec_then_done, busy, o_done, "request in work gave no result")
    `BSCSA_ASSERT_IMP(a_done_after_exec, o_done, $past(r_state == ST_EXEC), "stray result strobe")
    `BSCSA_ASSERT_IMP(a_grant_nonzero, o_done && (o_result.status == STAT_ALLOCATED), o_result.granted_slot != '0, "allocated slot zero")
    `BSCSA_ASSERT_IMP(a_nogrant_zero, o_done && (o_result.status != STAT_ALLOCATED), (o_result.granted_slot == '0) && (o_result.granted_bank == '0), "grant fields set without allocation")

endmodule

`default_nettype wire
